@@ rtl/fbao_pkg.sv @@
// ----------------------------------------------------------------------------
// fbao_pkg
// shared types and constants for the framebuffer alpha overlay engine
// ----------------------------------------------------------------------------
package fbao_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int X_W     = $clog2(MAX_WIDTH);
    localparam int Y_W     = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = X_W + Y_W;
    localparam int SIZE_W  = 9;
    localparam int COORD_W = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int PIX_W   = 32;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_BLEND  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_STATUS = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_EDGE    = 2'd2
    } t_status;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_BLEND_RD,
        S_BLEND_WR,
        S_READ_OUT
    } t_state;

    typedef struct packed {
        t_req_type          req_type;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [7:0]         in_red;
        logic [7:0]         in_green;
        logic [7:0]         in_blue;
        logic [7:0]         in_alpha;
    } t_req;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       error_seen;
        t_status    status;
    } t_res;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_cfg;

endpackage

@@ rtl/fbao_pixel_ram.sv @@
// ----------------------------------------------------------------------------
// fbao_pixel_ram
// single port pixel memory, one word per pixel, registered read data
// ----------------------------------------------------------------------------
module fbao_pixel_ram
    import fbao_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [PIX_W-1:0]  i_wdata,
    output logic [PIX_W-1:0]  o_rdata
);

    logic [PIX_W-1:0] r_mem [2**ADDR_W];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fbao_blend.sv @@
// ----------------------------------------------------------------------------
// fbao_blend
// colour mix datapath: registered products, then exact divide by 255
// ----------------------------------------------------------------------------
module fbao_blend
    import fbao_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [PIX_W-1:0] i_bg,
    input  t_req             i_fg,
    output logic [PIX_W-1:0] o_pixel
);

    logic [15:0] r_sum_r;
    logic [15:0] r_sum_g;
    logic [15:0] r_sum_b;
    logic [7:0]  r_keep_a;
    logic [7:0]  w_inv_a;

    function automatic logic [15:0] mix_sum(input logic [7:0] bg, input logic [7:0] fg,
                                            input logic [7:0] a, input logic [7:0] inv);
        logic [15:0] p_bg;
        logic [15:0] p_fg;
        p_bg = 16'(bg) * 16'(inv);
        p_fg = 16'(fg) * 16'(a);
        return 16'(p_bg + p_fg);
    endfunction

    // floor(s / 255) for s up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] s);
        logic [16:0] t;
        t = 17'(s) + 17'd1 + 17'(s >> 8);
        return t[15:8];
    endfunction

    assign w_inv_a = 8'd255 - i_fg.in_alpha;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum_r  <= mix_sum(i_bg[7:0],   i_fg.in_red,   i_fg.in_alpha, w_inv_a);
            r_sum_g  <= mix_sum(i_bg[15:8],  i_fg.in_green, i_fg.in_alpha, w_inv_a);
            r_sum_b  <= mix_sum(i_bg[23:16], i_fg.in_blue,  i_fg.in_alpha, w_inv_a);
            r_keep_a <= i_bg[31:24];
        end
    end

    assign o_pixel = {r_keep_a, div255(r_sum_b), div255(r_sum_g), div255(r_sum_r)};

endmodule

@@ rtl/fbao_cfg.sv @@
// ----------------------------------------------------------------------------
// fbao_cfg
// apb register bank for image width and height, clamped on write
// ----------------------------------------------------------------------------
module fbao_cfg
    import fbao_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > max) begin
            res = max;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_WIDTH:  n_cfg.width  = clamp_size(pwdata[SIZE_W-1:0], SIZE_W'(MAX_WIDTH));
                REG_HEIGHT: n_cfg.height = clamp_size(pwdata[SIZE_W-1:0], SIZE_W'(MAX_HEIGHT));
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_WIDTH:  prdata = PDATA_W'(r_cfg.width);
            REG_HEIGHT: prdata = PDATA_W'(r_cfg.height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= SIZE_W'(MAX_WIDTH);
            r_cfg.height <= SIZE_W'(MAX_HEIGHT);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/framebuffer_alpha_overlay.sv @@
// ----------------------------------------------------------------------------
// framebuffer_alpha_overlay
// rgba8888 framebuffer with clear, alpha overlay, pixel read and error status
//
// a request is transferred when start is high and busy is low; busy stays
// high until the engine can take the next one. every request gives exactly
// one result, shown on o_res for one cycle with o_strobe high.
// status requests, rejected overlays and rejected reads give their result in
// the cycle after the transfer. a pixel read passes the memory read and the
// output register; an overlay blend passes the memory read, the product
// register, then the divide and write. a clear writes every pixel of the
// width by height image, one pixel write per cycle. one request is in flight
// at a time; the single memory port sets the rate. image size registers sit
// on the apb port; the user must write them only while idle (not enforced).
// reset sets the size to 256 by 256, clears the sticky error and returns
// to idle; pixel contents are undefined until cleared or blended.
// the receiver cannot hold results off.
// ----------------------------------------------------------------------------
module framebuffer_alpha_overlay
    import fbao_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    output logic               o_strobe,
    output t_res               o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg              w_cfg;
    t_state            r_state;
    t_state            n_state;
    t_req              r_req;
    t_res              r_res;
    t_res              n_res;
    logic              r_strobe;
    logic              n_strobe;
    logic              r_sticky;
    logic              n_sticky;
    logic [X_W-1:0]    r_cx;
    logic [X_W-1:0]    n_cx;
    logic [Y_W-1:0]    r_cy;
    logic [Y_W-1:0]    n_cy;
    logic              w_accept;
    logic              w_past;
    logic              w_edge;
    logic              w_outside;
    logic              w_clr_last;
    logic              w_row_last;
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [PIX_W-1:0]  mem_wdata;
    logic [PIX_W-1:0]  mem_rdata;
    logic              blend_load;
    logic [PIX_W-1:0]  blend_pixel;

    fbao_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fbao_pixel_ram u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    fbao_blend u_blend (
        .i_clk   (i_clk),
        .i_load  (blend_load),
        .i_bg    (mem_rdata),
        .i_fg    (r_req),
        .o_pixel (blend_pixel)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_past    = (i_req.pos_x > w_cfg.width) || (i_req.pos_y > w_cfg.height);
    assign w_edge    = (i_req.pos_x == w_cfg.width) || (i_req.pos_y == w_cfg.height);
    assign w_outside = (i_req.pos_x >= w_cfg.width) || (i_req.pos_y >= w_cfg.height);

    assign w_row_last = (SIZE_W'(r_cx) == w_cfg.width - SIZE_W'(1));
    assign w_clr_last = w_row_last && (SIZE_W'(r_cy) == w_cfg.height - SIZE_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.req_type)
                        REQ_CLEAR: n_state = S_CLEAR;
                        REQ_BLEND: n_state = w_outside ? S_IDLE : S_BLEND_RD;
                        REQ_READ:  n_state = w_outside ? S_IDLE : S_READ_OUT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_BLEND_RD: n_state = S_BLEND_WR;
            S_BLEND_WR: n_state = S_IDLE;
            S_READ_OUT: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath control and result
    always_comb begin
        n_res      = '0;
        n_strobe   = 1'b0;
        n_sticky   = r_sticky;
        n_cx       = r_cx;
        n_cy       = r_cy;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = {i_req.pos_y[Y_W-1:0], i_req.pos_x[X_W-1:0]};
        mem_wdata  = blend_pixel;
        blend_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_cx = '0;
                n_cy = '0;
                if (w_accept) begin
                    case (i_req.req_type)
                        REQ_BLEND: begin
                            if (w_past) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_IGNORED;
                            end else if (w_edge) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_EDGE;
                                n_sticky     = 1'b1;
                            end else begin
                                mem_en = 1'b1;
                            end
                        end
                        REQ_READ: begin
                            if (w_outside) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_IGNORED;
                            end else begin
                                mem_en = 1'b1;
                            end
                        end
                        REQ_STATUS: begin
                            n_strobe         = 1'b1;
                            n_res.error_seen = r_sticky;
                            n_sticky         = 1'b0;
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = {r_cy, r_cx};
                mem_wdata = {r_req.in_alpha, r_req.in_blue, r_req.in_green, r_req.in_red};
                if (w_row_last) begin
                    n_cx = '0;
                    n_cy = r_cy + Y_W'(1);
                end else begin
                    n_cx = r_cx + X_W'(1);
                end
                if (w_clr_last) begin
                    n_strobe     = 1'b1;
                    n_res.status = ST_DONE;
                end
            end
            S_BLEND_RD: begin
                blend_load = 1'b1;
            end
            S_BLEND_WR: begin
                mem_en       = 1'b1;
                mem_we       = 1'b1;
                mem_addr     = {r_req.pos_y[Y_W-1:0], r_req.pos_x[X_W-1:0]};
                n_strobe     = 1'b1;
                n_res.status = ST_DONE;
            end
            S_READ_OUT: begin
                n_strobe        = 1'b1;
                n_res.out_red   = mem_rdata[7:0];
                n_res.out_green = mem_rdata[15:8];
                n_res.out_blue  = mem_rdata[23:16];
                n_res.out_alpha = mem_rdata[31:24];
                n_res.status    = ST_DONE;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_sticky <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_sticky <= n_sticky;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_cx  <= n_cx;
        r_cy  <= n_cy;
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_strobe_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept || r_state != S_IDLE))
        else $error("result without a request in flight");

    a_edge_sets_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.status == ST_EDGE) |-> r_sticky)
        else $error("edge error reported but sticky flag clear");

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.error_seen) |-> !r_sticky)
        else $error("sticky flag not cleared by status transfer");

endmodule
